>>> src/ofx_pkg.sv
// Odometry frame transform: shared types, constants and arithmetic helpers.
// No dependencies; imported by every module of the block.
package ofx_pkg;

    localparam int TRIG_BITS_DEF = 16;
    localparam int CORDIC_STEPS  = 18;
    localparam int CORDIC_LAT    = CORDIC_STEPS + 2;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CORDIC_GAIN = 652032874;
    localparam int LIN_SCALE   = 319816;
    localparam int ANG_SCALE   = 411538;
    localparam int RAD_TO_TURN = 683565276;
    localparam int INV_LIN     = 3437954;
    localparam int INV_ANG     = 2671716;

    typedef enum logic [1:0] {
        MODE_POS = 2'd0,
        MODE_VEL = 2'd1,
        MODE_ACC = 2'd2,
        MODE_SET = 2'd3
    } t_mode;

    localparam logic [2:0] REG_READY    = 3'd0;
    localparam logic [2:0] REG_UPSIDE   = 3'd1;
    localparam logic [2:0] REG_YAW      = 3'd2;
    localparam logic [2:0] REG_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y = 3'd4;

    typedef struct packed {
        logic               ready;
        logic               upside;
        logic signed [15:0] yaw;
        logic signed [15:0] off_x;
        logic signed [15:0] off_y;
    } t_ofx_cfg;

    typedef struct packed {
        t_mode              mode;
        logic               zero;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic signed [16:0] rh;
        logic signed [19:0] wx;
        logic signed [19:0] wy;
        logic signed [18:0] wh;
    } t_ofx_item;

    typedef struct packed {
        t_mode              mode;
        logic               zero;
        logic signed [19:0] xf;
        logic signed [19:0] yf;
        logic signed [18:0] hf;
        logic signed [19:0] wx;
        logic signed [19:0] wy;
        logic signed [18:0] wh;
    } t_ofx_mid;

    function automatic logic signed [33:0] f_atan(input int i);
        logic signed [33:0] r;
        case (i)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10680862;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // round to nearest, half away from zero, dropping s fraction bits
    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v, input int s);
        logic signed [63:0] m;
        logic signed [63:0] r;
        m = (v < 0) ? -v : v;
        r = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    function automatic logic signed [63:0] f_clamp(input logic signed [63:0] v,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
        logic signed [63:0] r;
        r = (v < lo) ? lo : ((v > hi) ? hi : v);
        return r;
    endfunction

endpackage

>>> src/ofx_cordic.sv
// Pipelined rotation-mode CORDIC: binary turn angle to cos and sin, Q1.15.
// Depends on ofx_pkg for the arctangent table and rounding helpers.
module ofx_cordic #(
    parameter int TRIG_BITS = ofx_pkg::TRIG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_ang,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);
    import ofx_pkg::*;

    localparam logic [31:0] Q    = 32'd1 << (31 - TRIG_BITS);
    localparam logic [31:0] MASK = ~((Q << 1) - 32'd1);

    logic signed [33:0] r_x [CORDIC_STEPS+1];
    logic signed [33:0] r_y [CORDIC_STEPS+1];
    logic signed [33:0] r_z [CORDIC_STEPS+1];
    logic               r_neg [CORDIC_STEPS+1];
    logic signed [15:0] r_cos, r_sin;

    logic [31:0] n_a, n_f;
    logic        n_neg;

    always_comb begin
        n_a   = (i_ang + Q) & MASK;
        n_neg = (n_a[31:30] == 2'd1) || (n_a[31:30] == 2'd2);
        n_f   = n_neg ? (n_a - 32'h8000_0000) : n_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= 34'(CORDIC_GAIN);
            r_y[0]   <= '0;
            r_z[0]   <= 34'($signed(n_f));
            r_neg[0] <= n_neg;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        logic signed [33:0] dx, dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - f_atan(g);
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + f_atan(g);
                end
            end
        end
    end

    logic signed [33:0] n_xo, n_yo;
    logic signed [63:0] n_c, n_s;

    always_comb begin
        n_xo = r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        n_yo = r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        n_c  = f_clamp(f_rnd(64'(n_xo), 15), -64'sd32768, 64'sd32767);
        n_s  = f_clamp(f_rnd(64'(n_yo), 15), -64'sd32768, 64'sd32767);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_c[15:0];
            r_sin <= n_s[15:0];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> src/ofx_front.sv
// Front end: accepts sensor words, classifies them and queues them for the back end.
// Depends on ofx_pkg for the item and configuration types.
module ofx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ofx_pkg::t_ofx_cfg   i_cfg,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [111:0]        s_axis_tdata,
    input  logic [2:0]          s_axis_tuser,
    input  logic                i_pop,
    output logic                o_avail,
    output ofx_pkg::t_ofx_item  o_item
);
    import ofx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_ofx_item          r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_cnt;
    t_ofx_item          n_item;
    logic               n_push;
    logic signed [16:0] n_rx, n_ry, n_rh;

    always_comb begin
        n_rx = 17'($signed(s_axis_tdata[15:0]));
        n_ry = 17'($signed(s_axis_tdata[31:16]));
        n_rh = 17'($signed(s_axis_tdata[47:32]));
        n_item.mode = t_mode'(s_axis_tuser[1:0]);
        n_item.zero = !i_cfg.ready || ((n_item.mode != MODE_ACC) &&
                                       (n_item.mode != MODE_SET) && !s_axis_tuser[2]);
        n_item.rx   = i_cfg.upside ? -n_rx : n_rx;
        n_item.ry   = i_cfg.upside ? -n_ry : n_ry;
        n_item.rh   = i_cfg.upside ? -n_rh : n_rh;
        n_item.wx   = $signed(s_axis_tdata[67:48]);
        n_item.wy   = $signed(s_axis_tdata[87:68]);
        n_item.wh   = $signed(s_axis_tdata[106:88]);
    end

    assign s_axis_tready = (r_cnt != (PTR_W+1)'(QUEUE_DEPTH));
    assign n_push        = s_axis_tvalid && s_axis_tready;
    assign o_avail       = (r_cnt != '0);
    assign o_item        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (n_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !n_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/ofx_back.sv
// Back end: scaling, rotation, lever-arm and inverse set path, one item per cycle.
// Depends on ofx_pkg and ofx_cordic; stalls as a whole when the output word waits.
module ofx_back #(
    parameter int TRIG_BITS = ofx_pkg::TRIG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ofx_pkg::t_ofx_cfg   i_cfg,
    input  logic                i_avail,
    input  ofx_pkg::t_ofx_item  i_item,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [111:0]        m_axis_tdata,
    output logic [0:0]          m_axis_tuser
);
    import ofx_pkg::*;

    logic en;
    assign en    = !m_axis_tvalid || m_axis_tready;
    assign o_pop = en && i_avail;

    // stage M1: scale products
    logic               r_m1_v;
    t_ofx_item          r_m1;
    logic signed [37:0] r_m1_px, r_m1_py;
    logic signed [37:0] r_m1_ph;
    logic signed [49:0] r_m1_pw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1    <= i_item;
            r_m1_px <= 38'(i_item.rx) * 38'(LIN_SCALE);
            r_m1_py <= 38'(i_item.ry) * 38'(LIN_SCALE);
            r_m1_ph <= 38'(i_item.rh) * 38'(ANG_SCALE);
            r_m1_pw <= 50'(i_item.wh) * 50'(RAD_TO_TURN);
        end
    end

    // stage M2: round, form angles
    logic               r_m2_v;
    t_ofx_mid           r_m2;
    logic [31:0]        r_m2_a1, r_m2_a2;
    logic signed [15:0] n_nyaw;
    logic signed [63:0] n_xf, n_yf, n_hf, n_ah;

    always_comb begin
        n_nyaw = -i_cfg.yaw;
        n_xf   = f_rnd(64'(r_m1_px), 16);
        n_yf   = f_rnd(64'(r_m1_py), 16);
        n_hf   = f_clamp(f_rnd(64'(r_m1_ph), 16), -64'sd262144, 64'sd262143);
        n_ah   = f_rnd(64'(r_m1_pw), 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2.mode <= r_m1.mode;
            r_m2.zero <= r_m1.zero;
            r_m2.xf   <= n_xf[19:0];
            r_m2.yf   <= n_yf[19:0];
            r_m2.hf   <= n_hf[18:0];
            r_m2.wx   <= r_m1.wx;
            r_m2.wy   <= r_m1.wy;
            r_m2.wh   <= r_m1.wh;
            r_m2_a1   <= {n_nyaw, 16'h0000};
            r_m2_a2   <= (r_m1.mode == MODE_SET) ? n_ah[31:0] : {r_m1.rh[15:0], 16'h0000};
        end
    end

    // trig units and matching payload delay
    logic signed [15:0] c, s, ch, sh;

    ofx_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r_m2_a1),
        .o_cos (c),
        .o_sin (s)
    );

    ofx_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic_head (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r_m2_a2),
        .o_cos (ch),
        .o_sin (sh)
    );

    t_ofx_mid r_dly [CORDIC_LAT];
    logic     r_dv  [CORDIC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CORDIC_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_m2_v;
            for (int i = 1; i < CORDIC_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= r_m2;
            for (int i = 1; i < CORDIC_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    t_ofx_mid d;
    assign d = r_dly[CORDIC_LAT-1];

    // E1: rotation and lever-arm products
    logic               r1_v;
    t_ofx_mid           r1_m;
    logic signed [15:0] r1_c, r1_s;
    logic signed [35:0] r1_p1, r1_p2, r1_p3, r1_p4;
    logic signed [31:0] r1_q1, r1_q2, r1_q3, r1_q4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m  <= d;
            r1_c  <= c;
            r1_s  <= s;
            r1_p1 <= 36'(c) * 36'(d.xf);
            r1_p2 <= 36'(s) * 36'(d.yf);
            r1_p3 <= 36'(s) * 36'(d.xf);
            r1_p4 <= 36'(c) * 36'(d.yf);
            r1_q1 <= 32'(ch) * 32'(i_cfg.off_x);
            r1_q2 <= 32'(sh) * 32'(i_cfg.off_y);
            r1_q3 <= 32'(sh) * 32'(i_cfg.off_x);
            r1_q4 <= 32'(ch) * 32'(i_cfg.off_y);
        end
    end

    // E2: round back to integer
    logic               r2_v;
    t_ofx_mid           r2_m;
    logic signed [15:0] r2_c, r2_s;
    logic signed [21:0] r2_x0, r2_y0;
    logic signed [18:0] r2_lx, r2_ly;
    logic signed [63:0] n2_x0, n2_y0, n2_lx, n2_ly;

    always_comb begin
        n2_x0 = f_rnd(64'(r1_p1) - 64'(r1_p2), 15);
        n2_y0 = f_rnd(64'(r1_p3) + 64'(r1_p4), 15);
        n2_lx = f_rnd(64'(r1_q1) - 64'(r1_q2), 15);
        n2_ly = f_rnd(64'(r1_q3) + 64'(r1_q4), 15);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_m  <= r1_m;
            r2_c  <= r1_c;
            r2_s  <= r1_s;
            r2_x0 <= n2_x0[21:0];
            r2_y0 <= n2_y0[21:0];
            r2_lx <= n2_lx[18:0];
            r2_ly <= n2_ly[18:0];
        end
    end

    // E3: subtract lever arm, or add it to the world pose
    logic               r3_v;
    t_ofx_mid           r3_m;
    logic signed [15:0] r3_c, r3_s;
    logic signed [22:0] r3_rx, r3_ry;
    logic signed [21:0] r3_px, r3_py;
    logic               n3_pos;

    assign n3_pos = (r2_m.mode == MODE_POS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_m  <= r2_m;
            r3_c  <= r2_c;
            r3_s  <= r2_s;
            r3_rx <= 23'(r2_x0) - (n3_pos ? 23'(r2_lx) : 23'sd0);
            r3_ry <= 23'(r2_y0) - (n3_pos ? 23'(r2_ly) : 23'sd0);
            r3_px <= 22'(r2_m.wx) + 22'(r2_lx);
            r3_py <= 22'(r2_m.wy) + 22'(r2_ly);
        end
    end

    // E4: saturate read results, un-rotate products for set
    logic               r4_v;
    t_ofx_mid           r4_m;
    logic signed [19:0] r4_ox, r4_oy;
    logic signed [37:0] r4_cpx, r4_spy, r4_cpy, r4_spx;
    logic signed [63:0] n4_ox, n4_oy;

    always_comb begin
        n4_ox = f_clamp(64'(r3_rx), -64'sd524288, 64'sd524287);
        n4_oy = f_clamp(64'(r3_ry), -64'sd524288, 64'sd524287);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_m   <= r3_m;
            r4_ox  <= n4_ox[19:0];
            r4_oy  <= n4_oy[19:0];
            r4_cpx <= 38'(r3_c) * 38'(r3_px);
            r4_spy <= 38'(r3_s) * 38'(r3_py);
            r4_cpy <= 38'(r3_c) * 38'(r3_py);
            r4_spx <= 38'(r3_s) * 38'(r3_px);
        end
    end

    // E5: un-rotated sums, mounting flip
    logic               r5_v;
    t_ofx_mid           r5_m;
    logic signed [19:0] r5_ox, r5_oy;
    logic signed [40:0] r5_xq, r5_yq;
    logic signed [19:0] r5_hq;
    logic signed [40:0] n5_xq, n5_yq;

    always_comb begin
        n5_xq = 41'(r4_cpx) + 41'(r4_spy);
        n5_yq = 41'(r4_cpy) - 41'(r4_spx);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_m  <= r4_m;
            r5_ox <= r4_ox;
            r5_oy <= r4_oy;
            r5_xq <= i_cfg.upside ? -n5_xq : n5_xq;
            r5_yq <= i_cfg.upside ? -n5_yq : n5_yq;
            r5_hq <= i_cfg.upside ? -20'(r4_m.wh) : 20'(r4_m.wh);
        end
    end

    // E6: inverse scale, split into partial products
    logic               r6_v;
    t_ofx_mid           r6_m;
    logic signed [19:0] r6_ox, r6_oy;
    logic signed [43:0] r6_xhk, r6_yhk;
    logic signed [43:0] r6_xlk, r6_ylk;
    logic signed [43:0] r6_hk;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_m   <= r5_m;
            r6_ox  <= r5_ox;
            r6_oy  <= r5_oy;
            r6_xhk <= 44'($signed(r5_xq[40:20])) * 44'(INV_LIN);
            r6_yhk <= 44'($signed(r5_yq[40:20])) * 44'(INV_LIN);
            r6_xlk <= 44'($signed({1'b0, r5_xq[19:0]})) * 44'(INV_LIN);
            r6_ylk <= 44'($signed({1'b0, r5_yq[19:0]})) * 44'(INV_LIN);
            r6_hk  <= 44'(r5_hq) * 44'(INV_ANG);
        end
    end

    // E7: combine partial products, heading word
    logic               r7_v;
    t_ofx_mid           r7_m;
    logic signed [19:0] r7_ox, r7_oy;
    logic signed [63:0] r7_xk, r7_yk;
    logic signed [15:0] r7_sh;
    logic signed [63:0] n7_sh;

    assign n7_sh = f_clamp(f_rnd(64'(r6_hk), 24), -64'sd32767, 64'sd32767);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_m  <= r6_m;
            r7_ox <= r6_ox;
            r7_oy <= r6_oy;
            r7_xk <= (64'(r6_xhk) <<< 20) + 64'(r6_xlk);
            r7_yk <= (64'(r6_yhk) <<< 20) + 64'(r6_ylk);
            r7_sh <= n7_sh[15:0];
        end
    end

    // E8: output word
    logic               r8_v;
    logic [111:0]       r8_data;
    logic               r8_user;
    logic signed [63:0] n8_sx, n8_sy;
    logic [111:0]       n8_data;
    logic               n8_user;
    logic signed [18:0] n8_h;

    always_comb begin
        n8_sx   = f_clamp(f_rnd(r7_xk, 39), -64'sd32767, 64'sd32767);
        n8_sy   = f_clamp(f_rnd(r7_yk, 39), -64'sd32767, 64'sd32767);
        n8_h    = (r7_m.mode == MODE_ACC) ? 19'sd0 : r7_m.hf;
        n8_data = '0;
        n8_user = 1'b0;
        if (!r7_m.zero) begin
            n8_user = 1'b1;
            if (r7_m.mode == MODE_SET) begin
                n8_data[74:59]  = n8_sx[15:0];
                n8_data[90:75]  = n8_sy[15:0];
                n8_data[106:91] = r7_sh;
            end else begin
                n8_data[19:0]   = r7_ox;
                n8_data[39:20]  = r7_oy;
                n8_data[58:40]  = n8_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_data <= n8_data;
            r8_user <= n8_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (en) begin
            r1_v <= r_dv[CORDIC_LAT-1];
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    assign m_axis_tvalid = r8_v;
    assign m_axis_tdata  = r8_data;
    assign m_axis_tuser  = r8_user;

endmodule

>>> src/odometry_frame_transform.sv
// Odometry frame transform top level: register port, front queue and back pipeline.
// Depends on ofx_pkg, ofx_front, ofx_back (and through it ofx_cordic).
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid / s_axis_tready    tdata sensor and world words, tuser mode, ok
//   m_axis    out  m_axis_tvalid / m_axis_tready    tdata robot-frame or set words, tuser valid
//   apb       in   psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One item a cycle sustained while the output is accepted; after acceptance an item passes
// the queue and the stages (scaling 2, CORDIC 20, back arithmetic 7, output 1).
// Synchronous active-low reset empties the queue and pipeline and clears the registers.
// An output stall freezes the back pipeline; the four-word queue keeps taking input until full.
module odometry_frame_transform #(
    parameter int TRIG_BITS = ofx_pkg::TRIG_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [15:0] raw_x, [31:16] raw_y, [47:32] raw_h, [67:48] world_x,
    // [87:68] world_y, [106:88] world_h, [111:107] zero
    input  logic [111:0]  s_axis_tdata,
    // [1:0] mode, [2] read_ok
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [19:0] out_x, [39:20] out_y, [58:40] out_h, [74:59] set_x,
    // [90:75] set_y, [106:91] set_h, [111:107] zero
    output logic [111:0]  m_axis_tdata,
    // [0] valid_res
    output logic [0:0]    m_axis_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import ofx_pkg::*;

    t_ofx_cfg  r_cfg;
    t_ofx_item item;
    logic      avail, pop;
    logic      wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (paddr[4:2])
                REG_READY:    r_cfg.ready  <= pwdata[0];
                REG_UPSIDE:   r_cfg.upside <= pwdata[0];
                REG_YAW:      r_cfg.yaw    <= pwdata[15:0];
                REG_OFFSET_X: r_cfg.off_x  <= pwdata[15:0];
                REG_OFFSET_Y: r_cfg.off_y  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_READY:    prdata = {31'd0, r_cfg.ready};
            REG_UPSIDE:   prdata = {31'd0, r_cfg.upside};
            REG_YAW:      prdata = 32'(r_cfg.yaw);
            REG_OFFSET_X: prdata = 32'(r_cfg.off_x);
            REG_OFFSET_Y: prdata = 32'(r_cfg.off_y);
            default:      prdata = '0;
        endcase
    end

    ofx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (pop),
        .o_avail       (avail),
        .o_item        (item)
    );

    ofx_back #(.TRIG_BITS(TRIG_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_avail       (avail),
        .i_item        (item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> dv/odometry_frame_transform_tb.sv
// Self-checking testbench for odometry_frame_transform: drives sensor and world words
// over the input stream, writes the registers over APB, and checks every output word.
// Depends on ofx_pkg for the mode and register codes.
`timescale 1ns / 1ps

module odometry_frame_transform_tb;
    import ofx_pkg::*;

    localparam int  CLK_HALF   = 5;
    localparam int  DRAIN_WAIT = 48;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rh;
        logic               ok;
        logic signed [19:0] wx;
        logic signed [19:0] wy;
        logic signed [18:0] wh;
    } t_sample;

    typedef struct packed {
        logic               vld;
        logic signed [19:0] ox;
        logic signed [19:0] oy;
        logic signed [18:0] oh;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sh;
    } t_pose;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [15:0] raw_x, [31:16] raw_y, [47:32] raw_h, [67:48] world_x,
    // [87:68] world_y, [106:88] world_h, [111:107] zero
    logic [111:0] s_axis_tdata;
    // [1:0] mode, [2] read_ok
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [19:0] out_x, [39:20] out_y, [58:40] out_h, [74:59] set_x,
    // [90:75] set_y, [106:91] set_h, [111:107] zero
    logic [111:0] m_axis_tdata;
    // [0] valid_res
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    odometry_frame_transform u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow registers
    logic               sh_ready;
    logic               sh_upside;
    logic signed [15:0] sh_yaw;
    logic signed [15:0] sh_off_x;
    logic signed [15:0] sh_off_y;

    t_pose  pose_expected[$];
    int     mismatches;
    longint cycles;
    int     burst_left;
    bit     gaps_on;
    int     stall_style;
    int     hold_len;
    int     hold_trig;
    int     hold_seen;
    int     hold_left;

    localparam longint ATAN_TURN [0:17] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215
    };

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint round_half(input longint v, input int s);
        longint h;
        h = longint'(1) <<< (s - 1);
        if (v < 0)
            return -((-v + h) >>> s);
        return (v + h) >>> s;
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void sincos_q15(input logic [31:0] ang, output longint co,
                                       output longint si);
        logic [31:0] a;
        bit          neg;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        a = (ang + 32'h0000_8000) & ~32'h0000_FFFF;
        neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (neg)
            a = a - 32'h8000_0000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 18; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURN[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURN[i];
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        co = sat(round_half(x, 15), -32768, 32767);
        si = sat(round_half(y, 15), -32768, 32767);
    endfunction

    function automatic logic [31:0] binary_angle(input longint w);
        logic [15:0] lo;
        lo = w[15:0];
        return {lo, 16'h0000};
    endfunction

    function automatic t_pose predict_pose(input t_sample it);
        t_pose  r;
        longint c, s, ch, sh;
        longint rx, ry, rh, xf, yf, hf, bx, by;
        longint px, py, xq, yq, hq;
        logic [31:0] ah;
        r = '{vld: 1'b0, ox: '0, oy: '0, oh: '0, sx: '0, sy: '0, sh: '0};
        if (!sh_ready)
            return r;
        sincos_q15(binary_angle(-longint'(sh_yaw)), c, s);
        if (it.mode != MODE_SET) begin
            if (it.mode != MODE_ACC && !it.ok)
                return r;
            rx = it.rx; ry = it.ry; rh = it.rh;
            if (sh_upside) begin
                rx = -rx; ry = -ry; rh = -rh;
            end
            xf = round_half(rx * LIN_SCALE, 16);
            yf = round_half(ry * LIN_SCALE, 16);
            hf = round_half(rh * ANG_SCALE, 16);
            bx = round_half(c * xf - s * yf, 15);
            by = round_half(s * xf + c * yf, 15);
            if (it.mode == MODE_POS) begin
                sincos_q15(binary_angle(rh), ch, sh);
                bx = bx - round_half(ch * sh_off_x - sh * sh_off_y, 15);
                by = by - round_half(sh * sh_off_x + ch * sh_off_y, 15);
            end
            if (it.mode == MODE_ACC)
                hf = 0;
            r.vld = 1'b1;
            r.ox = 20'(sat(bx, -524288, 524287));
            r.oy = 20'(sat(by, -524288, 524287));
            r.oh = 19'(sat(hf, -262144, 262143));
        end else begin
            ah = 32'(round_half(longint'(it.wh) * RAD_TO_TURN, 16));
            sincos_q15(ah, ch, sh);
            px = it.wx + round_half(ch * sh_off_x - sh * sh_off_y, 15);
            py = it.wy + round_half(sh * sh_off_x + ch * sh_off_y, 15);
            xq = c * px + s * py;
            yq = c * py - s * px;
            hq = it.wh;
            if (sh_upside) begin
                xq = -xq; yq = -yq; hq = -hq;
            end
            r.vld = 1'b1;
            r.sx = 16'(sat(round_half(xq * INV_LIN, 39), -32767, 32767));
            r.sy = 16'(sat(round_half(yq * INV_LIN, 39), -32767, 32767));
            r.sh = 16'(sat(round_half(hq * INV_ANG, 24), -32767, 32767));
        end
        return r;
    endfunction

    // receiver: own stall pattern plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_seen     <= 0;
        end else if (hold_trig != hold_seen) begin
            hold_seen     <= hold_trig;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                default: m_axis_tready <= cycles[2] ^ cycles[5];
            endcase
        end
    end

    // outputs are stable between edges; sample at the falling edge before acceptance
    always @(negedge i_clk) begin
        t_pose got;
        t_pose want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.vld = m_axis_tuser[0];
            got.ox  = m_axis_tdata[19:0];
            got.oy  = m_axis_tdata[39:20];
            got.oh  = m_axis_tdata[58:40];
            got.sx  = m_axis_tdata[74:59];
            got.sy  = m_axis_tdata[90:75];
            got.sh  = m_axis_tdata[106:91];
            if (pose_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
            end else begin
                want = pose_expected.pop_front();
                if (got != want || m_axis_tdata[111:107] != 5'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp v=%0d x=%0d y=%0d h=%0d sx=%0d sy=%0d",
                                  " sh=%0d | got v=%0d x=%0d y=%0d h=%0d sx=%0d sy=%0d sh=%0d"},
                                 want.vld, want.ox, want.oy, want.oh, want.sx, want.sy,
                                 want.sh, got.vld, got.ox, got.oy, got.oh, got.sx, got.sy,
                                 got.sh);
                end
            end
        end
    end

    task automatic send_sample(input t_sample it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tdata  <= {5'b0, it.wh, it.wy, it.wx, it.rh, it.ry, it.rx};
        s_axis_tuser  <= {it.ok, it.mode};
        s_axis_tvalid <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (s_axis_tready)
                break;
        end
        pose_expected.push_back(predict_pose(it));
        @(posedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pose_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_READY:    sh_ready  = val[0];
            REG_UPSIDE:   sh_upside = val[0];
            REG_YAW:      sh_yaw    = val[15:0];
            REG_OFFSET_X: sh_off_x  = val[15:0];
            REG_OFFSET_Y: sh_off_y  = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic rdy, input logic up, input logic [15:0] yaw,
                              input logic [15:0] ox, input logic [15:0] oy);
        drain();
        apb_write(REG_READY, {31'b0, rdy});
        apb_write(REG_UPSIDE, {31'b0, up});
        apb_write(REG_YAW, {16'b0, yaw});
        apb_write(REG_OFFSET_X, {16'b0, ox});
        apb_write(REG_OFFSET_Y, {16'b0, oy});
    endtask

    function automatic logic [31:0] pick_field(input int w);
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v = 32'h1 << (w - 1);
            1: v = ~(32'h1 << (w - 1));
            2: v = 32'h0;
            3: v = 32'hFFFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_sample random_sample();
        t_sample it;
        it.mode = t_mode'($urandom_range(0, 3));
        it.rx   = 16'(pick_field(16));
        it.ry   = 16'(pick_field(16));
        it.rh   = 16'(pick_field(16));
        it.ok   = ($urandom_range(0, 9) != 0);
        it.wx   = 20'(pick_field(20));
        it.wy   = 20'(pick_field(20));
        it.wh   = 19'(pick_field(19));
        return it;
    endfunction

    function automatic t_sample make_sample(input t_mode m, input logic [15:0] v,
                                            input logic ok, input logic [19:0] w);
        t_sample it;
        it.mode = m;
        it.rx = v; it.ry = ~v; it.rh = v;
        it.ok = ok;
        it.wx = w; it.wy = ~w; it.wh = w[18:0];
        return it;
    endfunction

    task automatic test_not_ready;
        send_sample(make_sample(MODE_POS, 16'h7FFF, 1'b1, 20'h7FFFF));
        send_sample(make_sample(MODE_ACC, 16'h8000, 1'b0, 20'h80000));
        send_sample(make_sample(MODE_SET, 16'h1234, 1'b1, 20'h12345));
    endtask

    task automatic test_directed;
        t_mode m;
        set_config(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        for (int k = 0; k < 4; k++) begin
            m = t_mode'(k);
            send_sample(make_sample(m, 16'h7FFF, 1'b1, 20'h7FFFF));
            send_sample(make_sample(m, 16'h8000, 1'b1, 20'h80000));
            send_sample(make_sample(m, 16'h0000, 1'b0, 20'h00000));
        end
        set_config(1'b1, 1'b1, 16'h8000, 16'h7FFF, 16'h8000);
        for (int k = 0; k < 4; k++) begin
            m = t_mode'(k);
            send_sample(make_sample(m, 16'h8000, 1'b1, 20'h80000));
            send_sample(make_sample(m, 16'h7FFF, 1'b0, 20'h3FFFF));
        end
        set_config(1'b1, 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(make_sample(MODE_POS, 16'h4000, 1'b1, 20'h40000));
        send_sample(make_sample(MODE_SET, 16'hC000, 1'b1, 20'h7FFFF));
        send_sample(make_sample(MODE_SET, 16'h0001, 1'b1, 20'h80000));
    endtask

    task automatic test_backpressure;
        gaps_on = 1'b0;
        hold_len = 300;
        hold_trig = hold_trig + 1;
        for (int k = 0; k < 60; k++)
            send_sample(random_sample());
        drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            if (p == 1)
                set_config(1'b0, 1'b1, 16'($urandom()), 16'($urandom()), 16'($urandom()));
            else
                set_config(1'b1, 1'($urandom_range(0, 1)), 16'(pick_field(16)),
                           16'(pick_field(16)), 16'(pick_field(16)));
            stall_style = p % 3;
            gaps_on = (p % 4 != 2);
            for (int k = 0; k < per_phase; k++)
                send_sample(random_sample());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cycles        = 0;
        mismatches    = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        stall_style   = 1;
        hold_len      = 0;
        hold_trig     = 0;
        sh_ready      = 1'b0;
        sh_upside     = 1'b0;
        sh_yaw        = '0;
        sh_off_x      = '0;
        sh_off_y      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_not_ready();
        test_directed();
        test_backpressure();
        test_random(8, 235);
        drain();

        if (mismatches == 0 && pose_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/ofx_pkg.sv
src/ofx_cordic.sv
src/ofx_front.sv
src/ofx_back.sv
src/odometry_frame_transform.sv
dv/odometry_frame_transform_tb.sv
